// ===== hw/rtl/tfg_pkg.sv =====
// Shared types, widths and codes for the trackball flick gesture detector.
// No dependencies; used by tfg_step and trackball_flick_gesture_detector.
package tfg_pkg;

	localparam int MOVE_BITS = 16;
	localparam int SUM_BITS  = 24;
	localparam int TIME_BITS = 32;

	localparam int SPEED_W = 15;
	localparam int MS_W    = 16;
	localparam int TOL_W   = 9;
	localparam int CMD_W   = 2;
	localparam int KEY_W   = 2;
	localparam int CODE_W  = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int IN_DATA_W  = ((2 * MOVE_BITS + TIME_BITS + 7) / 8) * 8;
	localparam int OUT_RAW_W  = 2 * MOVE_BITS + KEY_W + CODE_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam int MAX_REVERSALS = 2;
	localparam logic [TOL_W-1:0] TOL_MAX = TOL_W'(256);

	// commands
	localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd2;

	// key events / flick direction
	localparam logic [KEY_W-1:0] KEY_NONE = 2'd0;
	localparam logic [KEY_W-1:0] KEY_BACK = 2'd1;
	localparam logic [KEY_W-1:0] KEY_FWD  = 2'd2;

	// detector_state codes on the result
	localparam logic [CODE_W-1:0] CODE_IDLE   = 2'd0;
	localparam logic [CODE_W-1:0] CODE_DETECT = 2'd1;
	localparam logic [CODE_W-1:0] CODE_TRIG   = 2'd2;
	localparam logic [CODE_W-1:0] CODE_COOL   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_TOL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_SPEED = 3'd6;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_DETECT = 4'b0010,
		MODE_TRIG   = 4'b0100,
		MODE_COOL   = 4'b1000
	} mode_t;

	typedef struct packed {
		logic                enable;
		logic [SPEED_W-1:0]  start_speed;
		logic [SPEED_W-1:0]  min_distance;
		logic [MS_W-1:0]     window_ms;
		logic [MS_W-1:0]     cooldown_time;
		logic [TOL_W-1:0]    vertical_tolerance;
		logic [SPEED_W-1:0]  decay_speed;
	} cfg_t;

	typedef struct packed {
		mode_t                        mode;
		logic [KEY_W-1:0]             flick_direction;
		logic [TIME_BITS-1:0]         gesture_start;
		logic [TIME_BITS-1:0]         cooldown_start;
		logic signed [SUM_BITS-1:0]   sum_x;
		logic signed [SUM_BITS-1:0]   sum_y;
		logic signed [MOVE_BITS-1:0]  previous_dx;
		logic [1:0]                   reversal_count;
		logic                         consistent;
	} det_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]             command;
		logic signed [MOVE_BITS-1:0]  delta_x;
		logic signed [MOVE_BITS-1:0]  delta_y;
		logic [TIME_BITS-1:0]         time_ms;
	} item_t;

	typedef struct packed {
		logic signed [MOVE_BITS-1:0]  out_x;
		logic signed [MOVE_BITS-1:0]  out_y;
		logic [KEY_W-1:0]             key_event;
		logic [CODE_W-1:0]            detector_state;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		enable:             1'b1,
		start_speed:        SPEED_W'(15),
		min_distance:       SPEED_W'(50),
		window_ms:          MS_W'(200),
		cooldown_time:      MS_W'(300),
		vertical_tolerance: TOL_W'(128),
		decay_speed:        SPEED_W'(3)
	};

	localparam det_state_t STATE_CLEAR = '{
		mode:            MODE_IDLE,
		flick_direction: KEY_NONE,
		gesture_start:   '0,
		cooldown_start:  '0,
		sum_x:           '0,
		sum_y:           '0,
		previous_dx:     '0,
		reversal_count:  2'd0,
		consistent:      1'b1
	};

	function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
		logic [CODE_W-1:0] c;
		case (m)
			MODE_IDLE:   c = CODE_IDLE;
			MODE_DETECT: c = CODE_DETECT;
			MODE_TRIG:   c = CODE_TRIG;
			MODE_COOL:   c = CODE_COOL;
			default:     c = CODE_IDLE;
		endcase
		return c;
	endfunction

	// back to idle; timestamps are left alone
	function automatic det_state_t go_idle(input det_state_t s);
		det_state_t r;
		r = s;
		r.mode            = MODE_IDLE;
		r.flick_direction = KEY_NONE;
		r.sum_x           = '0;
		r.sum_y           = '0;
		r.previous_dx     = '0;
		r.reversal_count  = 2'd0;
		r.consistent      = 1'b1;
		return r;
	endfunction

endpackage

// ===== hw/rtl/trackball_flick_gesture_detector.sv =====
// Trackball flick gesture detector: top level with stream ports, register file,
// input register, detector state and result register. Depends on tfg_pkg, tfg_step.
//
// Each movement report or flick command beat yields exactly one result beat.
// The block takes one beat per clock while the output is not stalled: a beat is
// held in an input register, the detector step is combinational compare/add
// logic (the widest piece is the 9 x 23 bit vertical-ratio product), and the
// result and new detector state load together, so a following beat already
// sees the updated state. A stalled output holds the input register; a new
// beat is still taken while one result waits. Register writes are meant for
// idle periods; writing 0 to enable clears all detector state.
module trackball_flick_gesture_detector (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tfg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tfg_pkg::CFG_DATA_W-1:0]    cfg_data,

	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// delta_x [15:0], delta_y [31:16], time_ms [63:32]
	input  logic [tfg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// command [1:0]
	input  logic [tfg_pkg::CMD_W-1:0]         s_axis_tuser,

	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_x [15:0], out_y [31:16], key_event [33:32], detector_state [35:34], zeros above
	output logic [tfg_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import tfg_pkg::*;

	cfg_t       cfg_q;
	det_state_t state_q, state_next;
	item_t      item_s1;
	logic       valid_s1;
	result_t    step_res, res_q;
	logic       out_valid_q;
	logic       advance;
	logic       cfg_we;

	assign cfg_ready     = 1'b1;
	assign cfg_we        = cfg_valid && cfg_ready;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({res_q.detector_state, res_q.key_event,
	                                    res_q.out_y, res_q.out_x});

	tfg_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_next),
		.res  (step_res)
	);

	// register file; zero writes to speed, distance, window and cooldown fields and out-of-range tolerances are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:      cfg_q.enable <= cfg_data[0];
				REG_START_SPEED: if (cfg_data[SPEED_W-1:0] != '0)
					cfg_q.start_speed <= cfg_data[SPEED_W-1:0];
				REG_MIN_DIST:    if (cfg_data[SPEED_W-1:0] != '0)
					cfg_q.min_distance <= cfg_data[SPEED_W-1:0];
				REG_WINDOW:      if (cfg_data[MS_W-1:0] != '0)
					cfg_q.window_ms <= cfg_data[MS_W-1:0];
				REG_COOLDOWN:    if (cfg_data[MS_W-1:0] != '0)
					cfg_q.cooldown_time <= cfg_data[MS_W-1:0];
				REG_VERT_TOL:    if (cfg_data[TOL_W-1:0] <= TOL_MAX)
					cfg_q.vertical_tolerance <= cfg_data[TOL_W-1:0];
				REG_DECAY_SPEED: if (cfg_data[SPEED_W-1:0] != '0)
					cfg_q.decay_speed <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (cfg_we && cfg_index == REG_ENABLE && !cfg_data[0]) begin
			state_q <= STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.command <= s_axis_tuser;
			item_s1.delta_x <= s_axis_tdata[MOVE_BITS-1:0];
			item_s1.delta_y <= s_axis_tdata[2*MOVE_BITS-1:MOVE_BITS];
			item_s1.time_ms <= s_axis_tdata[2*MOVE_BITS+TIME_BITS-1:2*MOVE_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= step_res;
	end

	// a key tap only ever leaves on the beat that enters cooldown
	a_key_in_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.key_event != KEY_NONE) |-> res_q.detector_state == CODE_COOL)
		else $error("key event outside cooldown entry");

	// movement is consumed whenever the detector is busy
	a_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.detector_state != CODE_IDLE) |->
		(res_q.out_x == '0 && res_q.out_y == '0))
		else $error("movement leaked while detector busy");

	// saturated reversal count and lost consistency go together
	a_rev_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.reversal_count == 2'd3) == !state_q.consistent)
		else $error("reversal count and consistency disagree");

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q.mode))
		else $error("detector mode not one-hot");

endmodule

// ===== hw/rtl/tfg_step.sv =====
// Next-state and result logic for one item of the flick detector.
// Purely combinational; depends on tfg_pkg.
module tfg_step (
	input  tfg_pkg::cfg_t       cfg,
	input  tfg_pkg::det_state_t cur,
	input  tfg_pkg::item_t      item,
	output tfg_pkg::det_state_t nxt,
	output tfg_pkg::result_t    res
);
	import tfg_pkg::*;

	localparam int ABS_MV_W  = MOVE_BITS - 1;
	localparam int ABS_SUM_W = SUM_BITS - 1;
	localparam int CMP_W     = SUM_BITS + 8;

	logic signed [MOVE_BITS-1:0] dx;
	logic                        dx_neg, dx_pos, dx_min;
	logic [ABS_MV_W-1:0]         adx;
	logic [SPEED_W-1:0]          adx_w;

	logic [ABS_SUM_W-1:0]        ax, ay;
	logic [CMP_W-1:0]            ay_scaled, tol_ax;
	logic                        gesture_ok;
	logic [KEY_W-1:0]            sum_dir;

	logic [TIME_BITS-1:0]        gest_elapsed, cool_elapsed;
	logic                        window_over, cool_over;

	logic                        prev_pos, prev_nz, flipped, decayed, reversal;
	logic [1:0]                  rev_next;

	logic signed [SUM_BITS:0]    sx_wide, sy_wide;
	logic signed [SUM_BITS-1:0]  sx_sat, sy_sat;

	assign dx     = item.delta_x;
	assign dx_neg = dx[MOVE_BITS-1];
	assign dx_pos = !dx_neg && (dx != '0);
	assign dx_min = dx_neg && (dx[MOVE_BITS-2:0] == '0);
	assign adx    = dx_min ? {ABS_MV_W{1'b1}} :
	                dx_neg ? ABS_MV_W'(-dx) : ABS_MV_W'(dx);
	assign adx_w  = SPEED_W'(adx);

	// saturating absolute values of the sums
	assign ax = (cur.sum_x[SUM_BITS-1] && cur.sum_x[SUM_BITS-2:0] == '0) ? {ABS_SUM_W{1'b1}} :
	            cur.sum_x[SUM_BITS-1] ? ABS_SUM_W'(-cur.sum_x) : ABS_SUM_W'(cur.sum_x);
	assign ay = (cur.sum_y[SUM_BITS-1] && cur.sum_y[SUM_BITS-2:0] == '0) ? {ABS_SUM_W{1'b1}} :
	            cur.sum_y[SUM_BITS-1] ? ABS_SUM_W'(-cur.sum_y) : ABS_SUM_W'(cur.sum_y);

	// vertical ratio check: ay*256 <= tol*ax
	assign ay_scaled = CMP_W'({ay, 8'b0});
	assign tol_ax    = CMP_W'(cfg.vertical_tolerance) * CMP_W'(ax);

	assign gesture_ok = (ax >= ABS_SUM_W'(cfg.min_distance))
	                    && !((ax != '0) && (ay_scaled > tol_ax))
	                    && (cur.reversal_count <= 2'(MAX_REVERSALS))
	                    && cur.consistent;

	assign sum_dir = cur.sum_x[SUM_BITS-1] ? KEY_BACK :
	                 (cur.sum_x != '0)     ? KEY_FWD  : KEY_NONE;

	assign gest_elapsed = item.time_ms - cur.gesture_start;
	assign cool_elapsed = item.time_ms - cur.cooldown_start;
	assign window_over  = gest_elapsed > TIME_BITS'(cfg.window_ms);
	assign cool_over    = cool_elapsed >= TIME_BITS'(cfg.cooldown_time);

	assign prev_nz  = cur.previous_dx != '0;
	assign prev_pos = !cur.previous_dx[MOVE_BITS-1] && prev_nz;
	assign flipped  = prev_pos != dx_pos;
	assign decayed  = (adx_w < cfg.decay_speed)
	                  || (prev_nz && flipped && (adx_w > cfg.decay_speed));
	assign reversal = prev_nz && (dx != '0) && flipped;
	assign rev_next = (cur.reversal_count == 2'd3) ? 2'd3 : cur.reversal_count + 2'd1;

	// saturating accumulate, one guard bit
	assign sx_wide = {cur.sum_x[SUM_BITS-1], cur.sum_x} + (SUM_BITS+1)'(item.delta_x);
	assign sy_wide = {cur.sum_y[SUM_BITS-1], cur.sum_y} + (SUM_BITS+1)'(item.delta_y);
	assign sx_sat  = (sx_wide[SUM_BITS] == sx_wide[SUM_BITS-1]) ? sx_wide[SUM_BITS-1:0] :
	                 {sx_wide[SUM_BITS], {(SUM_BITS-1){~sx_wide[SUM_BITS]}}};
	assign sy_sat  = (sy_wide[SUM_BITS] == sy_wide[SUM_BITS-1]) ? sy_wide[SUM_BITS-1:0] :
	                 {sy_wide[SUM_BITS], {(SUM_BITS-1){~sy_wide[SUM_BITS]}}};

	always_comb begin
		nxt           = cur;
		res.out_x     = '0;
		res.out_y     = '0;
		res.key_event = KEY_NONE;

		if (item.command != CMD_MOVE) begin
			if (cfg.enable && (item.command == CMD_LEFT || item.command == CMD_RIGHT)) begin
				nxt.flick_direction = item.command;
				nxt.mode            = MODE_TRIG;
			end
		end else if (!cfg.enable) begin
			res.out_x = item.delta_x;
			res.out_y = item.delta_y;
		end else begin
			case (cur.mode)
				MODE_IDLE: begin
					if (adx_w >= cfg.start_speed) begin
						nxt.previous_dx    = dx;
						nxt.mode           = MODE_DETECT;
						nxt.gesture_start  = item.time_ms;
						nxt.sum_x          = '0;
						nxt.sum_y          = '0;
						nxt.reversal_count = 2'd0;
						nxt.consistent     = 1'b1;
					end
				end
				MODE_DETECT: begin
					if (window_over || decayed) begin
						if (gesture_ok) begin
							nxt.flick_direction = sum_dir;
							nxt.mode            = MODE_TRIG;
						end else begin
							nxt = go_idle(cur);
						end
					end else begin
						if (reversal) begin
							nxt.reversal_count = rev_next;
							if (rev_next > 2'(MAX_REVERSALS))
								nxt.consistent = 1'b0;
						end
						nxt.sum_x       = sx_sat;
						nxt.sum_y       = sy_sat;
						nxt.previous_dx = dx;
					end
				end
				MODE_TRIG: begin
					if (cur.flick_direction == KEY_BACK || cur.flick_direction == KEY_FWD)
						res.key_event = cur.flick_direction;
					nxt.mode           = MODE_COOL;
					nxt.cooldown_start = item.time_ms;
				end
				MODE_COOL: begin
					if (cool_over)
						nxt = go_idle(cur);
				end
				default: begin
					nxt = go_idle(cur);
				end
			endcase
			if (nxt.mode == MODE_IDLE) begin
				res.out_x = item.delta_x;
				res.out_y = item.delta_y;
			end
		end
		res.detector_state = mode_code(nxt.mode);
	end

endmodule

// ===== tb/trackball_flick_gesture_detector_tb.sv =====
// Self-checking testbench for the trackball flick gesture detector.
// Needs tfg_pkg and the detector RTL; drives reports, flick commands and register writes.
`timescale 1ns / 1ps

module trackball_flick_gesture_detector_tb;
	import tfg_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_RESERVED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam longint MOVE_MAX = (longint'(1) << (MOVE_BITS - 1)) - 1;
	localparam longint SUM_MAX  = (longint'(1) << (SUM_BITS - 1)) - 1;
	localparam int     STALL_CYCLES = 60;

	// Predicts one result per report and holds the results still owed by the block.
	class flick_scoreboard;
		logic                        enable;
		logic [SPEED_W-1:0]          start_speed, min_distance, decay_speed;
		logic [MS_W-1:0]             window_ms, cooldown_time;
		logic [TOL_W-1:0]            vert_tol;

		logic [CODE_W-1:0]           mode;
		logic [KEY_W-1:0]            direction;
		logic [TIME_BITS-1:0]        gesture_t0, cooldown_t0;
		logic signed [SUM_BITS-1:0]  sum_x, sum_y;
		logic signed [MOVE_BITS-1:0] prev_dx;
		logic [1:0]                  reversals;
		logic                        consistent;

		result_t     pending_results[$];
		int unsigned errors;

		function new();
			enable        = CFG_RESET.enable;
			start_speed   = CFG_RESET.start_speed;
			min_distance  = CFG_RESET.min_distance;
			window_ms     = CFG_RESET.window_ms;
			cooldown_time = CFG_RESET.cooldown_time;
			vert_tol      = CFG_RESET.vertical_tolerance;
			decay_speed   = CFG_RESET.decay_speed;
			errors        = 0;
			clear_detector();
		endfunction

		function void back_to_idle();
			mode       = CODE_IDLE;
			direction  = KEY_NONE;
			sum_x      = '0;
			sum_y      = '0;
			prev_dx    = '0;
			reversals  = 2'd0;
			consistent = 1'b1;
		endfunction

		function void clear_detector();
			gesture_t0  = '0;
			cooldown_t0 = '0;
			back_to_idle();
		endfunction

		function longint clip_mag(longint v, longint maxv);
			longint a;
			a = (v < 0) ? -v : v;
			return (a > maxv) ? maxv : a;
		endfunction

		function longint sat_sum(longint acc, longint d);
			longint r;
			r = acc + d;
			if (r > SUM_MAX)
				r = SUM_MAX;
			if (r < -SUM_MAX - 1)
				r = -SUM_MAX - 1;
			return r;
		endfunction

		function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
			REG_ENABLE: begin
				enable = value[0];
				if (!enable)
					clear_detector();
			end
			REG_START_SPEED: if (value[SPEED_W-1:0] != 0) start_speed = value[SPEED_W-1:0];
			REG_MIN_DIST:    if (value[SPEED_W-1:0] != 0) min_distance = value[SPEED_W-1:0];
			REG_WINDOW:      if (value[MS_W-1:0] != 0) window_ms = value[MS_W-1:0];
			REG_COOLDOWN:    if (value[MS_W-1:0] != 0) cooldown_time = value[MS_W-1:0];
			REG_VERT_TOL:    if (value[TOL_W-1:0] <= TOL_MAX) vert_tol = value[TOL_W-1:0];
			REG_DECAY_SPEED: if (value[SPEED_W-1:0] != 0) decay_speed = value[SPEED_W-1:0];
			default: ;
			endcase
		endfunction

		function void wrap_up_gesture();
			longint ax, ay;
			bit     ok;
			ax = clip_mag(sum_x, SUM_MAX);
			ay = clip_mag(sum_y, SUM_MAX);
			ok = consistent;
			if (ax < longint'(min_distance))
				ok = 0;
			if (ax > 0 && ay * 256 > longint'(vert_tol) * ax)
				ok = 0;
			if (reversals > MAX_REVERSALS)
				ok = 0;
			if (ok) begin
				direction = (sum_x < 0) ? KEY_BACK : ((sum_x > 0) ? KEY_FWD : KEY_NONE);
				mode      = CODE_TRIG;
			end else begin
				back_to_idle();
			end
		endfunction

		function result_t step_detector(item_t it);
			result_t              r;
			longint               adx;
			logic [TIME_BITS-1:0] elapsed;
			bit                   flipped;
			r   = '0;
			adx = clip_mag(it.delta_x, MOVE_MAX);
			flipped = (prev_dx != 0) && ((prev_dx > 0) != (it.delta_x > 0));
			if (it.command != CMD_MOVE) begin
				if (enable && (it.command == CMD_LEFT || it.command == CMD_RIGHT)) begin
					direction = (it.command == CMD_LEFT) ? KEY_BACK : KEY_FWD;
					mode      = CODE_TRIG;
				end
			end else if (!enable) begin
				r.out_x = it.delta_x;
				r.out_y = it.delta_y;
			end else begin
				case (mode)
				CODE_IDLE:
					if (adx >= longint'(start_speed)) begin
						prev_dx    = it.delta_x;
						mode       = CODE_DETECT;
						gesture_t0 = it.time_ms;
						sum_x      = '0;
						sum_y      = '0;
						reversals  = 2'd0;
						consistent = 1'b1;
					end
				CODE_DETECT: begin
					elapsed = it.time_ms - gesture_t0;
					if (elapsed > window_ms)
						wrap_up_gesture();
					else if (adx < longint'(decay_speed) || (flipped && adx > longint'(decay_speed)))
						wrap_up_gesture();
					else begin
						// a sign flip at exactly decay speed survives and counts as a reversal
						if (flipped && it.delta_x != 0) begin
							if (reversals < 2'd3)
								reversals++;
							if (reversals > MAX_REVERSALS)
								consistent = 1'b0;
						end
						sum_x   = SUM_BITS'(sat_sum(sum_x, it.delta_x));
						sum_y   = SUM_BITS'(sat_sum(sum_y, it.delta_y));
						prev_dx = it.delta_x;
					end
				end
				CODE_TRIG: begin
					if (direction == KEY_BACK || direction == KEY_FWD)
						r.key_event = direction;
					mode        = CODE_COOL;
					cooldown_t0 = it.time_ms;
				end
				default: begin
					elapsed = it.time_ms - cooldown_t0;
					if (elapsed >= cooldown_time)
						back_to_idle();
				end
				endcase
				if (mode == CODE_IDLE) begin
					r.out_x = it.delta_x;
					r.out_y = it.delta_y;
				end
			end
			r.detector_state = mode;
			return r;
		endfunction

		function void note_report(item_t it);
			pending_results.push_back(step_detector(it));
		endfunction

		function void check_result(result_t seen);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: expected none, actual x %0d y %0d key %0d state %0d",
					$time, seen.out_x, seen.out_y, seen.key_event, seen.detector_state);
				return;
			end
			want = pending_results.pop_front();
			if (seen.out_x !== want.out_x) begin
				errors++;
				$display("%0t: out_x expected %0d actual %0d", $time, want.out_x, seen.out_x);
			end
			if (seen.out_y !== want.out_y) begin
				errors++;
				$display("%0t: out_y expected %0d actual %0d", $time, want.out_y, seen.out_y);
			end
			if (seen.key_event !== want.key_event) begin
				errors++;
				$display("%0t: key_event expected %0d actual %0d", $time, want.key_event, seen.key_event);
			end
			if (seen.detector_state !== want.detector_state) begin
				errors++;
				$display("%0t: detector_state expected %0d actual %0d", $time,
					want.detector_state, seen.detector_state);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [CMD_W-1:0]      s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	flick_scoreboard      sb;
	int                   src_idle_pct;
	int                   rcv_idle_pct;
	bit                   stall_request;
	logic [TIME_BITS-1:0] clock_ms;

	trackball_flick_gesture_detector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin : watch_results
		result_t seen;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.out_x          = m_axis_tdata[MOVE_BITS-1:0];
			seen.out_y          = m_axis_tdata[2*MOVE_BITS-1:MOVE_BITS];
			seen.key_event      = m_axis_tdata[2*MOVE_BITS+KEY_W-1:2*MOVE_BITS];
			seen.detector_state = m_axis_tdata[2*MOVE_BITS+KEY_W+CODE_W-1:2*MOVE_BITS+KEY_W];
			sb.check_result(seen);
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				m_axis_tready <= 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
				stall_request = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int span(int lo, int hi);
		if (lo > 32767) lo = 32767;
		if (hi > 32767) hi = 32767;
		if (lo < 0) lo = 0;
		if (hi < 0) hi = 0;
		return int'($urandom_range(lo, hi));
	endfunction

	// entered and left at a falling edge; valid stays high across back-to-back beats
	task automatic send_report(input logic [CMD_W-1:0] cmd, input logic signed [MOVE_BITS-1:0] dx,
		input logic signed [MOVE_BITS-1:0] dy, input logic [TIME_BITS-1:0] stamp);
		item_t it;
		it.command = cmd;
		it.delta_x = dx;
		it.delta_y = dy;
		it.time_ms = stamp;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {stamp, dy, dx};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_report(it);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.load_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering and wait until every owed result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly well-formed gestures steered by the predicted detector state, with some noise.
	task automatic random_stretch(input int count);
		int                          roll, mag, step;
		bit                          neg, noise;
		logic [CMD_W-1:0]            cmd;
		logic signed [MOVE_BITS-1:0] dx, dy;
		logic [TIME_BITS-1:0]        stamp;
		repeat (count) begin
			roll  = $urandom_range(99);
			noise = (roll < 7);
			cmd   = CMD_MOVE;
			neg   = 1'($urandom_range(1));
			mag   = span(0, 40);
			step  = $urandom_range(0, 12);
			if (noise)
				cmd = CMD_W'($urandom_range(3));
			else if (roll < 11)
				cmd = $urandom_range(1) ? CMD_LEFT : CMD_RIGHT;
			else if (roll < 13)
				cmd = CMD_RESERVED;
			else begin
				case (sb.mode)
				CODE_IDLE:
					if ($urandom_range(3) != 0)
						mag = span(sb.start_speed, sb.start_speed + 200);
					else
						mag = span(0, sb.start_speed);
				CODE_DETECT: begin
					roll = $urandom_range(99);
					neg  = (sb.prev_dx < 0);
					step = $urandom_range(0, sb.window_ms / 8 + 1);
					if (roll < 55)
						mag = span(sb.decay_speed + 1, sb.decay_speed + 400);
					else if (roll < 67) begin
						neg = !neg;
						mag = sb.decay_speed;
					end else if (roll < 77)
						mag = span(0, sb.decay_speed - 1);
					else if (roll < 87) begin
						neg = !neg;
						mag = span(sb.decay_speed + 1, 32767);
					end else begin
						step = sb.window_ms + $urandom_range(1, 40);
						mag  = span(sb.decay_speed + 1, sb.decay_speed + 400);
					end
				end
				CODE_COOL:
					step = ($urandom_range(2) == 0) ? sb.cooldown_time + $urandom_range(0, 20)
						: $urandom_range(0, sb.cooldown_time / 3);
				default: ;
				endcase
			end
			dx = MOVE_BITS'(neg ? -mag : mag);
			if (neg && mag >= 32767 && $urandom_range(1))
				dx = 16'sh8000;
			case ($urandom_range(3))
			0: dy = '0;
			1: dy = MOVE_BITS'($urandom);
			default: begin
				dy = MOVE_BITS'($urandom_range(0, mag / 4));
				if ($urandom_range(1))
					dy = -dy;
			end
			endcase
			clock_ms = clock_ms + step;
			stamp    = clock_ms;
			if (noise) begin
				dx    = MOVE_BITS'($urandom);
				dy    = MOVE_BITS'($urandom);
				stamp = $urandom;
			end
			send_report(cmd, dx, dy, stamp);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_MOVE;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ENABLE;
		cfg_data      = '0;
		src_idle_pct  = 17;
		rcv_idle_pct  = 64;
		stall_request = 1'b0;
		clock_ms      = 32'd5000;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset settings: two tolerated reversals, decay end, key, cooldown
		send_report(CMD_MOVE, 0, 0, 32'd100);
		send_report(CMD_MOVE, 14, -5, 32'd110);
		send_report(CMD_MOVE, 15, 1, 32'd120);
		send_report(CMD_MOVE, 20, 2, 32'd130);
		send_report(CMD_MOVE, -3, 0, 32'd140);
		send_report(CMD_MOVE, 3, 0, 32'd150);
		send_report(CMD_MOVE, 40, 0, 32'd160);
		send_report(CMD_MOVE, 2, 0, 32'd170);
		send_report(CMD_MOVE, 5, 3, 32'd180);
		send_report(CMD_MOVE, 100, 0, 32'd479);
		send_report(CMD_MOVE, 7, -7, 32'd480);
		// third reversal spoils the gesture, then the window runs out
		send_report(CMD_MOVE, 16'sh8000, 16'sh7FFF, 32'd500);
		send_report(CMD_MOVE, 3, 0, 32'd510);
		send_report(CMD_MOVE, -3, 0, 32'd520);
		send_report(CMD_MOVE, 3, 0, 32'd530);
		send_report(CMD_MOVE, 16'sh8000, 16'sh8000, 32'd1000);
		// timestamp wrap inside a gesture, strong reversal ends it
		send_report(CMD_MOVE, 30, 0, 32'hFFFF_FFF0);
		send_report(CMD_MOVE, 30, 0, 32'd5);
		send_report(CMD_MOVE, 30, 0, 32'd10);
		send_report(CMD_MOVE, -4, 0, 32'd20);
		send_report(CMD_LEFT, 0, 0, 32'd25);
		send_report(CMD_RESERVED, -1, -1, 32'hFFFF_FFFF);
		send_report(CMD_MOVE, -1, 16'sh7FFF, 32'hFFFF_FF00);
		send_report(CMD_MOVE, 16'sh7FFF, 16'sh8000, 32'd44);
		send_report(CMD_RIGHT, 1, 1, 32'd50);
		send_report(CMD_MOVE, 0, 0, 32'd60);
		drain();
		// pass-through while disabled
		write_reg(REG_ENABLE, 16'hFFFE);
		send_report(CMD_MOVE, 16'sh8000, 16'sh7FFF, 32'd70);
		send_report(CMD_LEFT, 5, 5, 32'd80);
		send_report(CMD_RESERVED, 5, 5, 32'd90);
		send_report(CMD_MOVE, 100, -100, 32'd100);
		drain();
		write_reg(REG_ENABLE, 16'h0001);

		// every tuning register and an unmapped index, with writes that must be dropped
		write_reg(REG_START_SPEED, 16'h800F);
		write_reg(REG_START_SPEED, 16'h0000);
		write_reg(REG_MIN_DIST, 16'd50);
		write_reg(REG_WINDOW, 16'd200);
		write_reg(REG_COOLDOWN, 16'd300);
		write_reg(REG_VERT_TOL, 16'hFE80);
		write_reg(REG_VERT_TOL, 16'd257);
		write_reg(REG_VERT_TOL, 16'd300);
		write_reg(REG_DECAY_SPEED, 16'd3);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		random_stretch(30);
		drain();

		write_reg(REG_START_SPEED, 16'd1);
		write_reg(REG_MIN_DIST, 16'd1);
		write_reg(REG_MIN_DIST, 16'd0);
		write_reg(REG_WINDOW, 16'd1);
		write_reg(REG_WINDOW, 16'd0);
		write_reg(REG_COOLDOWN, 16'd1);
		write_reg(REG_COOLDOWN, 16'd0);
		write_reg(REG_VERT_TOL, 16'd0);
		write_reg(REG_DECAY_SPEED, 16'd1);
		write_reg(REG_DECAY_SPEED, 16'd0);
		random_stretch(25);
		drain();

		src_idle_pct = 64;
		rcv_idle_pct = 17;
		write_reg(REG_START_SPEED, 16'h7FFF);
		write_reg(REG_MIN_DIST, 16'hFFFF);
		write_reg(REG_WINDOW, 16'hFFFF);
		write_reg(REG_COOLDOWN, 16'hFFFF);
		write_reg(REG_VERT_TOL, 16'd256);
		write_reg(REG_DECAY_SPEED, 16'h7FFF);
		random_stretch(25);
		drain();

		write_reg(REG_START_SPEED, 16'd40);
		write_reg(REG_MIN_DIST, 16'd200);
		write_reg(REG_COOLDOWN, 16'd50);
		write_reg(REG_DECAY_SPEED, 16'd10);
		// long gesture that drives both sums into saturation
		send_report(CMD_MOVE, 16'sh7FFF, 0, clock_ms);
		repeat (258) send_report(CMD_MOVE, 16'sh7FFF, 16'sh8000, clock_ms);
		send_report(CMD_MOVE, 0, 0, clock_ms);
		random_stretch(20);
		drain();

		src_idle_pct = 0;
		rcv_idle_pct = 0;
		write_reg(REG_START_SPEED, 16'd100);
		write_reg(REG_MIN_DIST, 16'd300);
		write_reg(REG_WINDOW, 16'd500);
		write_reg(REG_COOLDOWN, 16'd100);
		write_reg(REG_VERT_TOL, 16'd64);
		write_reg(REG_DECAY_SPEED, 16'd20);
		clock_ms = 32'hFFFF_FE00;
		stall_request = 1'b1;
		random_stretch(30);
		drain();

		write_reg(REG_ENABLE, 16'h0000);
		random_stretch(10);
		drain();
		write_reg(REG_ENABLE, 16'h0001);
		random_stretch(20);

		s_axis_tvalid <= 1'b0;
		for (int i = 0; i < 5000 && sb.pending() != 0; i++) @(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
